// File: src/fpi_pkg.sv
// Shared constants, types and arithmetic helpers of the fuzzy PD inference block.
package fpi_pkg;

   localparam int IN_WIDTH_DEF = 16;
   localparam int FULL_SCALE   = 100;
   localparam int QUARTER      = FULL_SCALE / 4;
   localparam int DRIVE_WIDTH  = 8;

   // floor(y/3) as (y*RECIP3) >> RECIP3_SHIFT, exact for y < 2048
   localparam int RECIP3       = 683;
   localparam int RECIP3_SHIFT = 11;

   localparam int ERR_PTS  [4] = '{0, 12, 24, 48};
   localparam int RATE_PTS [4] = '{0, 16, 32, 64};
   localparam int CENTRES  [7] = '{0, 15, 30, 45, 60, 75, 90};
   localparam int RULE_TAB [7][7] = '{
      '{-6, -6, -6, -5, -5, -5, -4},
      '{-5, -4, -4, -3, -2, -2, -1},
      '{-4, -3, -2, -1,  0,  1,  2},
      '{-4, -3, -1,  0,  1,  3,  4},
      '{-2, -1,  0,  1,  2,  3,  4},
      '{ 1,  2,  2,  3,  4,  4,  5},
      '{ 4,  5,  5,  5,  6,  6,  6}
   };

   localparam int SEG_LOW  = -2;
   localparam int SEG_HIGH = 3;

   localparam logic SCALE_ERR  = 1'b0;
   localparam logic SCALE_RATE = 1'b1;

   localparam int QUO_BITS  = 7;
   localparam int MAG_WIDTH = 16;
   localparam int SUM_WIDTH = 9;
   localparam int ACC_WIDTH = 17;
   localparam int DIV_S1_LOW = 4;
   localparam int DIV_S2_LOW = 2;

   typedef logic signed [2:0] seg_type;
   typedef logic [6:0]        weight_type;
   typedef logic signed [3:0] label_type;
   typedef logic signed [7:0] centre_type;
   typedef weight_type weight_arr_type [4];
   typedef label_type  label_arr_type  [4];

   typedef struct packed {
      seg_type    seg;
      weight_type mu;
   } memb_type;

   typedef struct packed {
      memb_type err;
      memb_type rate;
   } fuzz_type;

   typedef struct packed {
      logic [MAG_WIDTH-1:0] mag;
      logic                 neg;
      logic [SUM_WIDTH-1:0] sum;
   } sums_type;

   typedef struct packed {
      logic [MAG_WIDTH-1:0] rem;
      logic [QUO_BITS-1:0]  quo;
      logic                 neg;
      logic [SUM_WIDTH-1:0] sum;
   } div_type;

   // Segment and mu0 for a value strictly inside the outer breakpoints.
   function automatic memb_type member(input logic signed [7:0] v, input logic scale);
      logic signed [7:0] p0, p1, p2, p3;
      logic signed [7:0] d;
      logic              wide;
      logic [9:0]        y;
      logic [19:0]       t;
      memb_type          m;
      p0 = (scale == SCALE_RATE) ? 8'(RATE_PTS[0]) : 8'(ERR_PTS[0]);
      p1 = (scale == SCALE_RATE) ? 8'(RATE_PTS[1]) : 8'(ERR_PTS[1]);
      p2 = (scale == SCALE_RATE) ? 8'(RATE_PTS[2]) : 8'(ERR_PTS[2]);
      p3 = (scale == SCALE_RATE) ? 8'(RATE_PTS[3]) : 8'(ERR_PTS[3]);
      if (v <= -p2) begin
         m.seg = 3'(SEG_LOW);  d = -p2 - v; wide = 1'b1;
      end else if (v <= -p1) begin
         m.seg = -3'sd1;       d = -p1 - v; wide = 1'b0;
      end else if (v <= p0) begin
         m.seg = 3'sd0;        d = -p0 - v; wide = 1'b0;
      end else if (v <= p1) begin
         m.seg = 3'sd1;        d = p1 - v;  wide = 1'b0;
      end else if (v <= p2) begin
         m.seg = 3'sd2;        d = p2 - v;  wide = 1'b0;
      end else begin
         m.seg = 3'(SEG_HIGH); d = p3 - v;  wide = 1'b1;
      end
      // 100*num/den: den is 12/24 on the error scale, 16/32 on the rate scale
      y = 10'(d[5:0]) * 10'(QUARTER);
      t = (20'(y) * 20'(RECIP3)) >> RECIP3_SHIFT;
      if (scale == SCALE_RATE) begin
         m.mu = wide ? 7'(y >> 3) : 7'(y >> 2);
      end else begin
         m.mu = wide ? 7'(t >> 1) : 7'(t);
      end
      return m;
   endfunction

   function automatic label_type rule_label(input logic [2:0] row, input logic [2:0] col);
      return 4'(RULE_TAB[row][col]);
   endfunction

   function automatic centre_type centre_of(input label_type lab);
      logic [2:0] k;
      centre_type c;
      k = lab[3] ? 3'(-lab) : 3'(lab);
      c = 8'(CENTRES[k]);
      return lab[3] ? -c : c;
   endfunction

   // Rules sharing an output label: keep only the larger weight.
   function automatic weight_arr_type dedup(input label_arr_type lab,
                                            input weight_arr_type w);
      weight_arr_type r;
      r = w;
      for (int i = 0; i < 4; i++) begin
         for (int j = i + 1; j < 4; j++) begin
            if (lab[i] == lab[j]) begin
               if (r[i] > r[j]) r[j] = '0;
               else r[i] = '0;
            end
         end
      end
      return r;
   endfunction

   // One restoring division step for quotient bit b.
   function automatic div_type div_step(input div_type d, input int b);
      logic [MAG_WIDTH-1:0] trial;
      div_type              r;
      r = d;
      trial = MAG_WIDTH'(d.sum) << b;
      if (d.rem >= trial) begin
         r.rem = d.rem - trial;
         r.quo = d.quo | (QUO_BITS'(1) << b);
      end
      return r;
   endfunction

endpackage

// File: src/fpi_req_if.sv
// Request channel: error and error rate with valid/ready handshake.
interface fpi_req_if #(parameter int IN_WIDTH = fpi_pkg::IN_WIDTH_DEF);
   logic                       valid;
   logic                       ready;
   logic signed [IN_WIDTH-1:0] error_value;
   logic signed [IN_WIDTH-1:0] error_rate;

   modport source (output valid, error_value, error_rate, input ready);
   modport sink   (input valid, error_value, error_rate, output ready);
endinterface

// File: src/fpi_rsp_if.sv
// Response channel: defuzzified drive value with valid/ready handshake.
interface fpi_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [fpi_pkg::DRIVE_WIDTH-1:0] drive_value;

   modport source (output valid, drive_value, input ready);
   modport sink   (input valid, drive_value, output ready);
endinterface

// File: src/fuzzy_pd_inference.sv
// Top level of the fuzzy PD inference pipeline (Mamdani 7x7, centroid output).
//
//  channel   dir  handshake              payload
//  req_chan  in   valid/ready (sink)     error_value, error_rate (IN_WIDTH, signed)
//  rsp_chan  out  valid/ready (source)   drive_value (8 bit signed, -90..90)
//
// Six register stages: fuzzify, rule weights, weighted sums, three divider stages.
// One request per cycle sustained while rsp ready holds; rsp valid rises once the request
// has passed through all six register stages.
// The restoring divider spreads seven quotient bits over three stages.
// Reset (synchronous) clears only the stage valid bits; no state survives a request.
// Each stage holds on a stall and fills bubbles, so req ready drops only when full.
module fuzzy_pd_inference #(
   parameter int IN_WIDTH = fpi_pkg::IN_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   fpi_req_if.sink    req_chan,
   fpi_rsp_if.source  rsp_chan
);

   localparam int DRIVE_MAX = fpi_pkg::CENTRES[6];

   // fuzzify -> rules
   logic              fz_valid, fz_ready;
   fpi_pkg::fuzz_type fz_data;

   // rules -> divider
   logic              sm_valid, sm_ready;
   fpi_pkg::sums_type sm_data;

   fpi_fuzzify #(.IN_WIDTH(IN_WIDTH)) u_fuzzify (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .error_value (req_chan.error_value),
      .error_rate  (req_chan.error_rate),
      .out_valid   (fz_valid),
      .out_ready   (fz_ready),
      .out_data    (fz_data)
   );

   // two stages: min weights with label pruning, then signed sums
   fpi_rules u_rules (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fz_valid),
      .in_ready  (fz_ready),
      .in_data   (fz_data),
      .out_valid (sm_valid),
      .out_ready (sm_ready),
      .out_data  (sm_data)
   );

   // last divider stage doubles as the output register
   fpi_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sm_valid),
      .in_ready  (sm_ready),
      .in_data   (sm_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.drive_value)
   );

   // centroid of centres in -90..90 can never leave that range
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.drive_value >= -DRIVE_MAX)
                      && (rsp_chan.drive_value <= DRIVE_MAX))
      else $error("drive_value out of range");

   // an open response side keeps every stage open
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.ready |-> req_chan.ready)
      else $error("request side blocked while response side ready");

   // with no backpressure an accepted request always reaches rsp valid
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) ##1 rsp_chan.ready ##1 rsp_chan.ready
      ##1 rsp_chan.ready ##1 rsp_chan.ready ##1 rsp_chan.ready |=> rsp_chan.valid)
      else $error("request lost in pipeline");

endmodule

// File: src/fpi_fuzzify.sv
// Fuzzification stage: segment and membership of error and error rate.
module fpi_fuzzify #(
   parameter int IN_WIDTH = fpi_pkg::IN_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [IN_WIDTH-1:0] error_value,
   input  logic signed [IN_WIDTH-1:0] error_rate,
   output logic                       out_valid,
   input  logic                       out_ready,
   output fpi_pkg::fuzz_type          out_data
);

   localparam logic signed [IN_WIDTH-1:0] ERR_HI  = IN_WIDTH'(fpi_pkg::ERR_PTS[3]);
   localparam logic signed [IN_WIDTH-1:0] ERR_LO  = IN_WIDTH'(-fpi_pkg::ERR_PTS[3]);
   localparam logic signed [IN_WIDTH-1:0] RATE_HI = IN_WIDTH'(fpi_pkg::RATE_PTS[3]);
   localparam logic signed [IN_WIDTH-1:0] RATE_LO = IN_WIDTH'(-fpi_pkg::RATE_PTS[3]);

   logic              valid_ff;
   fpi_pkg::fuzz_type fuzz_ff, fuzz_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = fuzz_ff;

   always_comb begin
      if (error_value <= ERR_LO) begin
         fuzz_in.err.seg = 3'(fpi_pkg::SEG_LOW);
         fuzz_in.err.mu  = 7'(fpi_pkg::FULL_SCALE);
      end else if (error_value >= ERR_HI) begin
         fuzz_in.err.seg = 3'(fpi_pkg::SEG_HIGH);
         fuzz_in.err.mu  = '0;
      end else begin
         fuzz_in.err = fpi_pkg::member($signed(error_value[7:0]), fpi_pkg::SCALE_ERR);
      end
      if (error_rate <= RATE_LO) begin
         fuzz_in.rate.seg = 3'(fpi_pkg::SEG_LOW);
         fuzz_in.rate.mu  = 7'(fpi_pkg::FULL_SCALE);
      end else if (error_rate >= RATE_HI) begin
         fuzz_in.rate.seg = 3'(fpi_pkg::SEG_HIGH);
         fuzz_in.rate.mu  = '0;
      end else begin
         fuzz_in.rate = fpi_pkg::member($signed(error_rate[7:0]), fpi_pkg::SCALE_RATE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         fuzz_ff <= fuzz_in;
      end
   end

endmodule

// File: src/fpi_rules.sv
// Rule evaluation (labels, min weights, duplicate pruning) and weighted sums.
module fpi_rules (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpi_pkg::fuzz_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output fpi_pkg::sums_type out_data
);

   logic [2:0]                    e_lo, e_hi, r_lo, r_hi;
   fpi_pkg::weight_type           pe0, pe1, pr0, pr1;
   fpi_pkg::label_arr_type        lab_in, lab_ff;
   fpi_pkg::weight_arr_type       w_raw, w_in, w_ff;
   logic                          valid_a_ff, valid_b_ff;
   logic                          ready_a, ready_b;
   logic signed [fpi_pkg::ACC_WIDTH-1:0] acc;
   fpi_pkg::sums_type             sums_ff, sums_in;

   assign ready_b   = !valid_b_ff || out_ready;
   assign ready_a   = !valid_a_ff || ready_b;
   assign in_ready  = ready_a;
   assign out_valid = valid_b_ff;
   assign out_data  = sums_ff;

   // stage A: four firing rules
   always_comb begin
      e_lo = in_data.err.seg + 3'd2;
      e_hi = in_data.err.seg + 3'd3;
      r_lo = in_data.rate.seg + 3'd2;
      r_hi = in_data.rate.seg + 3'd3;
      pe0 = in_data.err.mu;
      pe1 = 7'(fpi_pkg::FULL_SCALE) - in_data.err.mu;
      pr0 = in_data.rate.mu;
      pr1 = 7'(fpi_pkg::FULL_SCALE) - in_data.rate.mu;
      lab_in[0] = fpi_pkg::rule_label(e_lo, r_lo);
      lab_in[1] = fpi_pkg::rule_label(e_hi, r_lo);
      lab_in[2] = fpi_pkg::rule_label(e_lo, r_hi);
      lab_in[3] = fpi_pkg::rule_label(e_hi, r_hi);
      w_raw[0] = (pe0 <= pr0) ? pe0 : pr0;
      w_raw[1] = (pe1 <= pr0) ? pe1 : pr0;
      w_raw[2] = (pe0 <= pr1) ? pe0 : pr1;
      w_raw[3] = (pe1 <= pr1) ? pe1 : pr1;
      w_in = fpi_pkg::dedup(lab_in, w_raw);
   end

   // stage B: signed weighted sum and weight sum
   always_comb begin
      acc = '0;
      sums_in.sum = '0;
      for (int i = 0; i < 4; i++) begin
         acc = acc + fpi_pkg::ACC_WIDTH'($signed({1'b0, w_ff[i]})
                                        * fpi_pkg::centre_of(lab_ff[i]));
         sums_in.sum = sums_in.sum + fpi_pkg::SUM_WIDTH'(w_ff[i]);
      end
      sums_in.neg = acc[fpi_pkg::ACC_WIDTH-1];
      sums_in.mag = sums_in.neg ? fpi_pkg::MAG_WIDTH'(-acc) : fpi_pkg::MAG_WIDTH'(acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) valid_a_ff <= in_valid;
         if (ready_b) valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         lab_ff <= lab_in;
         w_ff   <= w_in;
      end
      if (ready_b && valid_a_ff) begin
         sums_ff <= sums_in;
      end
   end

endmodule

// File: src/fpi_divide.sv
// Three-stage restoring divider for the centroid, with sign and zero handling.
module fpi_divide (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  fpi_pkg::sums_type                       in_data,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic signed [fpi_pkg::DRIVE_WIDTH-1:0] out_data
);

   fpi_pkg::div_type d1_in, d1_ff, d2_in, d2_ff, d3;
   logic             v1_ff, v2_ff, v3_ff;
   logic             rdy1, rdy2, rdy3;
   logic signed [fpi_pkg::DRIVE_WIDTH-1:0] drive_ff, drive_in;

   assign rdy3      = !v3_ff || out_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign in_ready  = rdy1;
   assign out_valid = v3_ff;
   assign out_data  = drive_ff;

   always_comb begin
      d1_in.rem = in_data.mag;
      d1_in.quo = '0;
      d1_in.neg = in_data.neg;
      d1_in.sum = in_data.sum;
      for (int b = fpi_pkg::QUO_BITS - 1; b >= fpi_pkg::DIV_S1_LOW; b--) begin
         d1_in = fpi_pkg::div_step(d1_in, b);
      end
   end

   always_comb begin
      d2_in = d1_ff;
      for (int b = fpi_pkg::DIV_S1_LOW - 1; b >= fpi_pkg::DIV_S2_LOW; b--) begin
         d2_in = fpi_pkg::div_step(d2_in, b);
      end
   end

   always_comb begin
      d3 = d2_ff;
      for (int b = fpi_pkg::DIV_S2_LOW - 1; b >= 0; b--) begin
         d3 = fpi_pkg::div_step(d3, b);
      end
      if (d3.sum == '0) begin
         drive_in = '0;
      end else if (d3.neg) begin
         drive_in = -fpi_pkg::DRIVE_WIDTH'(d3.quo);
      end else begin
         drive_in = fpi_pkg::DRIVE_WIDTH'(d3.quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) d1_ff <= d1_in;
      if (rdy2 && v1_ff)    d2_ff <= d2_in;
      if (rdy3 && v2_ff)    drive_ff <= drive_in;
   end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the fuzzy PD inference pipeline: directed, random, backpressure.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IN_W = 16;

   // Scale breakpoints (the zero point is implied) and the output label spacing.
   localparam int ERR_B1  = 12;
   localparam int ERR_B2  = 24;
   localparam int ERR_B3  = 48;
   localparam int RATE_B1 = 16;
   localparam int RATE_B2 = 32;
   localparam int RATE_B3 = 64;
   localparam int PERCENT = 100;
   localparam int CENTRE_STEP = 15;

   // Output label per (error label + 3, rate label + 3).
   localparam int RULES [7][7] = '{
      '{-6, -6, -6, -5, -5, -5, -4},
      '{-5, -4, -4, -3, -2, -2, -1},
      '{-4, -3, -2, -1,  0,  1,  2},
      '{-4, -3, -1,  0,  1,  3,  4},
      '{-2, -1,  0,  1,  2,  3,  4},
      '{ 1,  2,  2,  3,  4,  4,  5},
      '{ 4,  5,  5,  5,  6,  6,  6}
   };

   // Nothing accepted on either channel for this many cycles ends the run.
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 90;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      logic signed [IN_W-1:0] error_value;
      logic signed [IN_W-1:0] error_rate;
      logic signed [7:0]      drive_value;
   } drive_entry_type;

   logic clock = 1'b0;
   logic reset;

   fpi_req_if #(.IN_WIDTH(IN_W)) req_chan ();
   fpi_rsp_if                    rsp_chan ();

   fuzzy_pd_inference #(.IN_WIDTH(IN_W)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   drive_entry_type expected_drives [$];
   int error_count     = 0;
   int requests_sent   = 0;
   int drives_checked  = 0;
   int input_stalls    = 0;
   int idle_cycles     = 0;
   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int hold_left       = 0;
   logic hold_req      = 1'b0;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Segment number and left-hand membership (percent) of x on a scale
   // with breakpoints 0/b1/b2/b3, mirrored for negative values.
   function automatic void fuzzify(input int x, input int b1, input int b2, input int b3,
                                   output int seg, output int mu0);
      int num;
      int den;
      num = 0;
      den = 1;
      if (x <= -b3) begin
         seg = -2;
         mu0 = PERCENT;
      end else if (x >= b3) begin
         seg = 3;
         mu0 = 0;
      end else begin
         if (x <= -b2) begin
            seg = -2; num = -b2 - x; den = b3 - b2;
         end else if (x <= -b1) begin
            seg = -1; num = -b1 - x; den = b2 - b1;
         end else if (x <= 0) begin
            seg = 0;  num = -x;      den = b1;
         end else if (x <= b1) begin
            seg = 1;  num = b1 - x;  den = b1;
         end else if (x <= b2) begin
            seg = 2;  num = b2 - x;  den = b2 - b1;
         end else begin
            seg = 3;  num = b3 - x;  den = b3 - b2;
         end
         mu0 = (PERCENT * num) / den;
      end
   endfunction

   // Expected drive value for one request.
   function automatic logic signed [7:0] predict_drive(input int err, input int rate);
      int e_seg, e_mu, r_seg, r_mu;
      int acc, total, q;
      int e_deg [2];
      int r_deg [2];
      int wt [4];
      int lab [4];
      fuzzify(err, ERR_B1, ERR_B2, ERR_B3, e_seg, e_mu);
      fuzzify(rate, RATE_B1, RATE_B2, RATE_B3, r_seg, r_mu);
      e_deg[0] = e_mu;  e_deg[1] = PERCENT - e_mu;
      r_deg[0] = r_mu;  r_deg[1] = PERCENT - r_mu;
      // rule k: error side k%2, rate side k/2
      for (int k = 0; k < 4; k++) begin
         lab[k] = RULES[e_seg + 2 + k % 2][r_seg + 2 + k / 2];
         wt[k]  = (e_deg[k % 2] <= r_deg[k / 2]) ? e_deg[k % 2] : r_deg[k / 2];
      end
      // shared output label: the weaker rule drops out, the earlier one on a tie
      for (int i = 0; i < 4; i++) begin
         for (int j = i + 1; j < 4; j++) begin
            if (lab[i] == lab[j]) begin
               if (wt[i] > wt[j]) wt[j] = 0;
               else wt[i] = 0;
            end
         end
      end
      acc = 0;
      total = 0;
      for (int k = 0; k < 4; k++) begin
         acc   += wt[k] * CENTRE_STEP * lab[k];
         total += wt[k];
      end
      q = (total != 0) ? acc / total : 0;   // int division truncates toward zero
      return 8'(q);
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one request after a random idle gap; returns once it is accepted.
   // valid stays high afterwards so back-to-back requests need no extra edge.
   task automatic send_request(input logic signed [IN_W-1:0] err,
                               input logic signed [IN_W-1:0] rate);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.error_value <= err;
      req_chan.error_rate  <= rate;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_drives.push_back('{err, rate, predict_drive(int'(err), int'(rate))});
      requests_sent++;
   endtask

   // Drop valid so the last request is not taken twice.
   task automatic quiet_request();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly values within the scales, some near or exactly on the breakpoints, some anywhere.
   function automatic logic signed [IN_W-1:0] pick_input(input int outer);
      int kind;
      int v;
      kind = $urandom_range(9);
      if (kind < 7) begin
         v = int'($urandom_range(2 * outer + 16)) - (outer + 8);
      end else if (kind == 7) begin
         v = (outer >> $urandom_range(2)) + int'($urandom_range(2)) - 1;
         if ($urandom_range(1) == 1) v = -v;
      end else begin
         v = $urandom;
      end
      return IN_W'(v);
   endfunction

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // ready toggles randomly, or is held low for a counted stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_req) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= HOLD_CYCLES - 1;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input drive_entry_type ent,
                                  input logic signed [7:0] got);
      $display("mismatch (%s): error %0d rate %0d -> drive %0d, expected %0d",
               what, ent.error_value, ent.error_rate, got, ent.drive_value);
      error_count++;
   endtask

   // Compare every accepted response with the oldest outstanding request.
   always @(posedge clock) begin
      drive_entry_type ent;
      if (!reset) begin
         if (req_chan.valid && !req_chan.ready) input_stalls++;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_drives.size() == 0) begin
               ent = '{0, 0, 0};
               report_mismatch("no request outstanding", ent, rsp_chan.drive_value);
            end else begin
               ent = expected_drives.pop_front();
               if (rsp_chan.drive_value !== ent.drive_value)
                  report_mismatch("drive_value", ent, rsp_chan.drive_value);
               drives_checked++;
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", idle_cycles);
         $display("[fuzzy_pd_inference] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, breakpoints on both sides, saturation below and above the
   // scales, 50/50 memberships (weight ties) and labels shared between rules.
   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_request(-16'sd32768, -16'sd32768);  // below both scales, duplicate labels
      send_request( 16'sd32767,  16'sd32767);  // above both scales
      send_request( 16'sd0,      16'sd0);
      send_request(-16'sd32768,  16'sd32767);
      send_request( 16'sd32767, -16'sd32768);
      send_request( 16'sd48,     16'sd64);     // exactly on the outer points
      send_request(-16'sd48,    -16'sd64);
      send_request( 16'sd47,     16'sd63);
      send_request(-16'sd47,    -16'sd63);
      send_request( 16'sd12,     16'sd16);
      send_request(-16'sd12,    -16'sd16);
      send_request( 16'sd24,     16'sd32);
      send_request(-16'sd24,    -16'sd32);
      send_request( 16'sd6,      16'sd8);      // equal weights on every rule
      send_request(-16'sd6,     -16'sd8);
      send_request( 16'sd1,     -16'sd1);
      send_request(-16'sd1,      16'sd1);
      send_request( 16'sd36,     16'sd48);
      send_request(-16'sd36,    -16'sd48);
      send_request( 16'sd13,    -16'sd17);
      send_request(-16'sd25,     16'sd33);
      send_request(-16'sd16384,  16'sd100);
      send_request( 16'sd21845, -16'sd21846);  // alternating bit patterns
      send_request(-16'sd21846,  16'sd21845);
      quiet_request();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_request(pick_input(ERR_B3), pick_input(RATE_B3));
      quiet_request();
   endtask

   // Response side stalls for a long stretch while requests keep coming,
   // so the pipeline fills and must push back on its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      repeat (30) send_request(pick_input(ERR_B3), pick_input(RATE_B3));
      quiet_request();
   endtask

   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.error_value <= '0;
      req_chan.error_rate  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic(9, 67, 160);
      test_random_traffic(67, 9, 160);
      test_random_traffic(0, 0, 160);
      test_backpressure();

      // let the pipeline drain, then a few cycles for any stray response
      recv_idle_pct = 0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_drives.size() != 0) begin
         $display("%0d requests never answered", expected_drives.size());
         error_count++;
      end

      $display("run: %0d requests (directed extremes, random under both stall mixes, bursts)",
               requests_sent);
      $display("run: %0d drive values checked, input held off for %0d cycles in total",
               drives_checked, input_stalls);
      if (error_count == 0) begin
         $display("[fuzzy_pd_inference] OK");
      end else begin
         $display("[fuzzy_pd_inference] ERROR");
      end
      $finish;
   end

endmodule
